>>> design/rgbgray_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgray_pkg
// Shared constants, codes and types of the RGB to grey luma converter.
// ----------------------------------------------------------------------------
package rgbgray_pkg;

    // channel codes wider than this lose their low bits before linearizing
    localparam int DEGAMMA_INDEX_BITS = 16;

    localparam int CODE_W    = 16;
    localparam int ROOT_BITS = 20;             // fifth root in Q16, below 2^20
    localparam int PW2       = 40;
    localparam int PW3       = 60;
    localparam int PW4       = 80;
    localparam int PW5       = 101;
    localparam int CSQ_W     = 2 * CODE_W;
    localparam int PROD_W    = CSQ_W + ROOT_BITS;
    localparam int LIN_W     = PROD_W - 4;
    localparam int TGT_W     = LIN_W + 1;
    localparam int LIN_LAT   = ROOT_BITS + 1;
    localparam int STEPS     = CODE_W;

    localparam int RED16 = CODE_W - DEGAMMA_INDEX_BITS;
    localparam int RED10 = (DEGAMMA_INDEX_BITS >= 10) ? 0 : 10 - DEGAMMA_INDEX_BITS;
    localparam logic [CODE_W-1:0] RED_MASK16 = 16'hFFFF << RED16;
    localparam logic [CODE_W-1:0] RED_MASK10 = 16'hFFFF << RED10;

    localparam logic [14:0] WIDTH_LIMIT = 15'd800;

    // Q0.16 weights, R G B
    localparam logic [15:0] W601_R = 16'd19595;
    localparam logic [15:0] W601_G = 16'd38470;
    localparam logic [15:0] W601_B = 16'd7471;
    localparam logic [15:0] W709_R = 16'd13933;
    localparam logic [15:0] W709_G = 16'd46871;
    localparam logic [15:0] W709_B = 16'd4732;

    typedef enum logic [2:0] {
        FMT_BGRA8  = 3'd0,
        FMT_ARGB8  = 3'd1,
        FMT_BGRA16 = 3'd2,
        FMT_ARGB16 = 3'd3,
        FMT_RGB10  = 3'd4
    } t_fmt;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_GAMMA  = 2'd1,
        REG_WIDTH  = 2'd2
    } t_reg;

    // everything a pixel carries down the pipe besides the channel codes
    typedef struct packed {
        logic [2:0]        fmt;
        logic              gmode;
        logic [31:0]       w0;
        logic [31:0]       w1;
        logic [15:0]       basic;
        logic [TGT_W-1:0]  tgt;
        logic [15:0]       lum;
    } t_side;

    // is this bit position part of the format's code range
    function automatic logic step_active(logic [2:0] fmt, int bitpos);
        logic act;
        case (fmt)
            FMT_BGRA8, FMT_ARGB8:   act = (bitpos < 8);
            FMT_BGRA16, FMT_ARGB16: act = (bitpos < 16);
            FMT_RGB10:              act = (bitpos < 10);
            default:                act = 1'b0;
        endcase
        return act;
    endfunction

endpackage

>>> design/rgb_pixel_to_gray_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_to_gray_luma
// Packed pixel to grey: luma written into the colour fields, alpha kept.
// From start to o_done a pixel passes the input registers, the channel linearizers
// and the 16-step luma search, each step a linearizer and a compare register.
// Throughput is one pixel per clock; busy stays low and the result side cannot
// stall. Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module rgb_pixel_to_gray_luma (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_word_first,
    input  logic [31:0] i_word_second,
    output logic        o_done,
    output logic [31:0] o_gray_first,
    output logic [31:0] o_gray_second,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import rgbgray_pkg::*;

    localparam int LATENCY = 6 + LIN_LAT + STEPS * (LIN_LAT + 1);

    logic [2:0]  r_fmt;
    logic        r_gmode;
    logic [14:0] r_width;
    logic        accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= '0;
            r_gmode <= 1'b0;
            r_width <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg'(i_cfg_index))
                REG_FORMAT: r_fmt   <= i_cfg_data[2:0];
                REG_GAMMA:  r_gmode <= i_cfg_data[0];
                REG_WIDTH:  r_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- unpack ----------------
    logic [15:0] u_r, u_g, u_b;
    logic [15:0] u_mask;
    t_side       u_side;

    always_comb begin
        u_r    = '0;
        u_g    = '0;
        u_b    = '0;
        u_mask = 16'hFFFF;
        case (r_fmt)
            FMT_BGRA8: begin
                u_r = 16'(i_word_first[23:16]);
                u_g = 16'(i_word_first[15:8]);
                u_b = 16'(i_word_first[7:0]);
            end
            FMT_ARGB8: begin
                u_r = 16'(i_word_first[15:8]);
                u_g = 16'(i_word_first[23:16]);
                u_b = 16'(i_word_first[31:24]);
            end
            FMT_BGRA16: begin
                u_r    = i_word_second[15:0];
                u_g    = i_word_first[31:16];
                u_b    = i_word_first[15:0];
                u_mask = RED_MASK16;
            end
            FMT_ARGB16: begin
                u_r    = i_word_first[31:16];
                u_g    = i_word_second[15:0];
                u_b    = i_word_second[31:16];
                u_mask = RED_MASK16;
            end
            FMT_RGB10: begin
                u_r    = 16'(i_word_first[31:22]);
                u_g    = 16'(i_word_first[21:12]);
                u_b    = 16'(i_word_first[11:2]);
                u_mask = RED_MASK10;
            end
            default: ;
        endcase
        u_side       = '0;
        u_side.fmt   = r_fmt;
        u_side.gmode = r_gmode;
        u_side.w0    = i_word_first;
        u_side.w1    = i_word_second;
    end

    logic        r_e_v;
    logic        r_e_709;
    logic [15:0] r_e_r, r_e_g, r_e_b;
    logic [15:0] r_e_cr, r_e_cg, r_e_cb;
    t_side       r_e_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_709  <= (r_width > WIDTH_LIMIT) || (r_fmt == FMT_RGB10);
        r_e_r    <= u_r;
        r_e_g    <= u_g;
        r_e_b    <= u_b;
        r_e_cr   <= u_r & u_mask;
        r_e_cg   <= u_g & u_mask;
        r_e_cb   <= u_b & u_mask;
        r_e_side <= u_side;
    end

    // ---------------- basic weighted sum ----------------
    logic        r_m_v;
    logic [31:0] r_m_pr, r_m_pg, r_m_pb;
    logic [15:0] r_m_cr, r_m_cg, r_m_cb;
    t_side       r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else begin
            r_m_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_pr   <= 32'(r_e_r) * 32'(r_e_709 ? W709_R : W601_R);
        r_m_pg   <= 32'(r_e_g) * 32'(r_e_709 ? W709_G : W601_G);
        r_m_pb   <= 32'(r_e_b) * 32'(r_e_709 ? W709_B : W601_B);
        r_m_cr   <= r_e_cr;
        r_m_cg   <= r_e_cg;
        r_m_cb   <= r_e_cb;
        r_m_side <= r_e_side;
    end

    logic [33:0] m_sum;
    logic        r_f_v;
    logic [15:0] r_f_cr, r_f_cg, r_f_cb;
    t_side       r_f_side;
    t_side       n_f_side;

    assign m_sum = 34'(r_m_pr) + 34'(r_m_pg) + 34'(r_m_pb);

    always_comb begin
        n_f_side       = r_m_side;
        n_f_side.basic = m_sum[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_cr   <= r_m_cr;
        r_f_cg   <= r_m_cg;
        r_f_cb   <= r_m_cb;
        r_f_side <= n_f_side;
    end

    // ---------------- channel linearizers ----------------
    logic             lr_v;
    logic [LIN_W-1:0] lr_lin, lg_lin, lb_lin;
    t_side            lr_side;

    rgbgray_lin u_lin_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_code  (r_f_cr),
        .i_side  (r_f_side),
        .o_valid (lr_v),
        .o_lin   (lr_lin),
        .o_side  (lr_side)
    );

    rgbgray_lin u_lin_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_code  (r_f_cg),
        .i_side  (r_f_side),
        .o_valid (),
        .o_lin   (lg_lin),
        .o_side  ()
    );

    rgbgray_lin u_lin_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_code  (r_f_cb),
        .i_side  (r_f_side),
        .o_valid (),
        .o_lin   (lb_lin),
        .o_side  ()
    );

    logic        r_w_v;
    logic [63:0] r_w_pr, r_w_pg, r_w_pb;
    t_side       r_w_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v <= 1'b0;
        end else begin
            r_w_v <= lr_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_pr   <= 64'(lr_lin) * 64'(W709_R);
        r_w_pg   <= 64'(lg_lin) * 64'(W709_G);
        r_w_pb   <= 64'(lb_lin) * 64'(W709_B);
        r_w_side <= lr_side;
    end

    logic [65:0] w_sum;
    logic        r_t_v;
    t_side       r_t_side;
    t_side       n_t_side;

    assign w_sum = 66'(r_w_pr) + 66'(r_w_pg) + 66'(r_w_pb);

    // lin(L) << 16 <= S is the same test as lin(L) <= S >> 16
    always_comb begin
        n_t_side     = r_w_side;
        n_t_side.tgt = w_sum[16 +: TGT_W];
        n_t_side.lum = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else begin
            r_t_v <= r_w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_side <= n_t_side;
    end

    // ---------------- re-encode: one luma bit per linearizer ----------------
    logic  s_v    [STEPS+1];
    t_side s_side [STEPS+1];
    logic  r_u_v    [STEPS];
    t_side r_u_side [STEPS];

    assign s_v[0]    = r_t_v;
    assign s_side[0] = r_t_side;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int BITPOS = STEPS - 1 - k;

        logic             iv;
        logic [LIN_W-1:0] ilin;
        t_side            iside;
        t_side            n_side;
        logic [15:0]      cand_in;
        logic [15:0]      cand_out;
        logic             keep;

        assign cand_in  = s_side[k].lum | (16'd1 << BITPOS);
        assign cand_out = iside.lum | (16'd1 << BITPOS);
        assign keep     = step_active(iside.fmt, BITPOS) && (TGT_W'(ilin) <= iside.tgt);

        rgbgray_lin u_lin (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[k]),
            .i_code  (cand_in),
            .i_side  (s_side[k]),
            .o_valid (iv),
            .o_lin   (ilin),
            .o_side  (iside)
        );

        always_comb begin
            n_side     = iside;
            n_side.lum = keep ? cand_out : iside.lum;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_u_v[k] <= 1'b0;
            end else begin
                r_u_v[k] <= iv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_u_side[k] <= n_side;
        end

        assign s_v[k+1]    = r_u_v[k];
        assign s_side[k+1] = r_u_side[k];
    end

    // ---------------- repack ----------------
    t_side       f_side;
    logic [15:0] f_lum;
    logic [31:0] n_out0, n_out1;

    assign f_side = s_side[STEPS];
    assign f_lum  = f_side.gmode ? f_side.lum : f_side.basic;

    always_comb begin
        n_out0 = '0;
        n_out1 = '0;
        case (f_side.fmt)
            FMT_BGRA8:  n_out0 = {f_side.w0[31:24], f_lum[7:0], f_lum[7:0], f_lum[7:0]};
            FMT_ARGB8:  n_out0 = {f_lum[7:0], f_lum[7:0], f_lum[7:0], f_side.w0[7:0]};
            FMT_BGRA16: begin
                n_out0 = {f_lum, f_lum};
                n_out1 = {f_side.w1[31:16], f_lum};
            end
            FMT_ARGB16: begin
                n_out0 = {f_lum, f_side.w0[15:0]};
                n_out1 = {f_lum, f_lum};
            end
            FMT_RGB10:  n_out0 = {f_lum[9:0], f_lum[9:0], f_lum[9:0], 2'b00};
            default: ;
        endcase
    end

    logic        r_done;
    logic [31:0] r_out0, r_out1;
    logic [2:0]  r_o_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_v[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out0  <= n_out0;
        r_out1  <= n_out1;
        r_o_fmt <= f_side.fmt;
    end

    assign o_done        = r_done;
    assign o_gray_first  = r_out0;
    assign o_gray_second = r_out1;

    // ---------------- checks ----------------
    a_fixed_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a start beat at fixed latency");

    a_second_word_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !(r_o_fmt == FMT_BGRA16 || r_o_fmt == FMT_ARGB16))
        |-> (o_gray_second == 32'd0))
        else $error("second word nonzero for a single-word format");

endmodule

>>> design/rgbgray_lin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbgray_lin
// Pipelined linearizer: lin(c) = (c * c * q) >> 4, q the Q16 fifth root of c.
// One root bit per stage, powers of q kept incrementally; side data rides along.
// ----------------------------------------------------------------------------
module rgbgray_lin (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [15:0]               i_code,
    input  rgbgray_pkg::t_side        i_side,
    output logic                      o_valid,
    output logic [rgbgray_pkg::LIN_W-1:0] o_lin,
    output rgbgray_pkg::t_side        o_side
);
    import rgbgray_pkg::*;

    logic                 r_v    [ROOT_BITS];
    logic [CODE_W-1:0]    r_code [ROOT_BITS];
    logic [CSQ_W-1:0]     r_csq  [ROOT_BITS];
    logic [ROOT_BITS-1:0] r_q    [ROOT_BITS];
    logic [PW2-1:0]       r_p2   [ROOT_BITS];
    logic [PW3-1:0]       r_p3   [ROOT_BITS];
    logic [PW4-1:0]       r_p4   [ROOT_BITS];
    logic [PW5-1:0]       r_p5   [ROOT_BITS];
    t_side                r_side [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        localparam int B = ROOT_BITS - 1 - k;

        logic                 v_in;
        logic [CODE_W-1:0]    code_in;
        logic [CSQ_W-1:0]     csq_in;
        logic [ROOT_BITS-1:0] q_in;
        logic [PW2-1:0]       p2_in;
        logic [PW3-1:0]       p3_in;
        logic [PW4-1:0]       p4_in;
        logic [PW5-1:0]       p5_in;
        t_side                side_in;
        logic [PW2-1:0]       c2;
        logic [PW3-1:0]       c3;
        logic [PW4-1:0]       c4;
        logic [PW5-1:0]       c5;
        logic                 take;

        if (k == 0) begin : g_head
            assign v_in    = i_valid;
            assign code_in = i_code;
            assign csq_in  = CSQ_W'(i_code) * CSQ_W'(i_code);
            assign q_in    = '0;
            assign p2_in   = '0;
            assign p3_in   = '0;
            assign p4_in   = '0;
            assign p5_in   = '0;
            assign side_in = i_side;
        end else begin : g_tail
            assign v_in    = r_v[k-1];
            assign code_in = r_code[k-1];
            assign csq_in  = r_csq[k-1];
            assign q_in    = r_q[k-1];
            assign p2_in   = r_p2[k-1];
            assign p3_in   = r_p3[k-1];
            assign p4_in   = r_p4[k-1];
            assign p5_in   = r_p5[k-1];
            assign side_in = r_side[k-1];
        end

        // binomial expansion of (q + 2^B)^n
        always_comb begin
            c2 = p2_in + (PW2'(q_in) << (B + 1)) + (PW2'(1) << (2 * B));
            c3 = p3_in + ((PW3'(p2_in) * PW3'(3)) << B)
               + ((PW3'(q_in) * PW3'(3)) << (2 * B)) + (PW3'(1) << (3 * B));
            c4 = p4_in + ((PW4'(p3_in) * PW4'(4)) << B)
               + ((PW4'(p2_in) * PW4'(6)) << (2 * B))
               + ((PW4'(q_in) * PW4'(4)) << (3 * B)) + (PW4'(1) << (4 * B));
            c5 = p5_in + ((PW5'(p4_in) * PW5'(5)) << B)
               + ((PW5'(p3_in) * PW5'(10)) << (2 * B))
               + ((PW5'(p2_in) * PW5'(10)) << (3 * B))
               + ((PW5'(q_in) * PW5'(5)) << (4 * B)) + (PW5'(1) << (5 * B));
            take = (c5 <= (PW5'(code_in) << 80));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_code[k] <= code_in;
            r_csq[k]  <= csq_in;
            r_side[k] <= side_in;
            if (take) begin
                r_q[k]  <= q_in | (ROOT_BITS'(1) << B);
                r_p2[k] <= c2;
                r_p3[k] <= c3;
                r_p4[k] <= c4;
                r_p5[k] <= c5;
            end else begin
                r_q[k]  <= q_in;
                r_p2[k] <= p2_in;
                r_p3[k] <= p3_in;
                r_p4[k] <= p4_in;
                r_p5[k] <= p5_in;
            end
        end
    end

    logic [PROD_W-1:0] prod;
    logic              r_mv;
    logic [LIN_W-1:0]  r_lin;
    t_side             r_mside;

    assign prod = PROD_W'(r_csq[ROOT_BITS-1]) * PROD_W'(r_q[ROOT_BITS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_v[ROOT_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lin   <= prod[PROD_W-1:4];
        r_mside <= r_side[ROOT_BITS-1];
    end

    assign o_valid = r_mv;
    assign o_lin   = r_lin;
    assign o_side  = r_mside;

endmodule
